>>> hdl/modular_exponentiation_top_assert.svh
// Assertion macros used by the checker file.
`ifndef MODULAR_EXPONENTIATION_TOP_ASSERT_SVH
`define MODULAR_EXPONENTIATION_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed in the next cycle");

`endif

>>> hdl/modexp_pkg.sv
package modexp_pkg;

	localparam int unsigned ModexpWidth = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} modexp_state_t;

endpackage

>>> hdl/modular_exponentiation_top.sv
// Channel  Handshake                  Payload
// input    in_valid / in_ready        base, exponent, modulus
// output   out_valid / out_ready      power, mod_error
//
// One word is taken at a time; in_ready is high only while the block is idle.
// A word with a zero base, exponent or modulus goes straight to the done state and its output register.
// Otherwise the base is first reduced, then one square runs per exponent bit above bit 0 up to the top
// set bit and one multiply per set exponent bit; one multiplier bit is handled a cycle.
// Reset clears the controller and the output valid; no data register is reset.
// A stalled output holds its word, and a finished word waits there for out_ready.
module modular_exponentiation_top
	import modexp_pkg::*;
#(
	parameter int unsigned WIDTH = ModexpWidth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] base,
	input  logic [WIDTH-1:0] exponent,
	input  logic [WIDTH-1:0] modulus,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] power,
	output logic             mod_error
);

	localparam int unsigned CW = (WIDTH > 2) ? $clog2(WIDTH) : 1;
	localparam logic [CW-1:0] CNT_INIT = CW'(WIDTH - 1);
	localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

	modexp_state_t state_q, state_d;

	logic [WIDTH-1:0] base_q, exp_q, mod_q, acc_q;
	logic [WIDTH-1:0] ma_q, mb_q, mp_q;
	logic [CW-1:0]    cnt_q;
	logic             err_q;
	logic             out_valid_q;
	logic [WIDTH-1:0] power_q;
	logic             mod_error_q;

	logic             cnt_last;
	logic             special;
	logic             out_free;
	logic [WIDTH-1:0] sum_p, sum_a, mp_next, red_v, one_mod;
	logic [WIDTH:0]   red_t;

	function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
		input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] m);
		logic [WIDTH:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[WIDTH-1:0];
	endfunction

	assign cnt_last = (cnt_q == '0);
	assign special  = (base == '0) || (exponent == '0) || (modulus == '0);
	assign out_free = !out_valid_q || out_ready;
	assign sum_p    = add_mod(mp_q, ma_q, mod_q);
	assign sum_a    = add_mod(ma_q, ma_q, mod_q);
	assign mp_next  = mb_q[0] ? sum_p : mp_q;
	assign red_t    = {mp_q, base_q[WIDTH-1]};
	assign red_v    = (red_t >= {1'b0, mod_q}) ? WIDTH'(red_t - {1'b0, mod_q})
	                                           : red_t[WIDTH-1:0];
	assign one_mod  = (mod_q == ONE) ? '0 : ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = special ? ST_DONE : ST_RED;
				end
			end
			ST_RED: begin
				if (cnt_last) begin
					state_d = exp_q[0] ? ST_MUL : ST_SQR;
				end
			end
			ST_MUL: begin
				if (cnt_last) begin
					state_d = (exp_q[WIDTH-1:1] == '0) ? ST_DONE : ST_SQR;
				end
			end
			ST_SQR: begin
				if (cnt_last) begin
					state_d = exp_q[1] ? ST_MUL : ST_SQR;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					base_q <= base;
					exp_q  <= exponent;
					mod_q  <= modulus;
					mp_q   <= '0;
					cnt_q  <= CNT_INIT;
					acc_q  <= (base != '0 && exponent == '0) ? ONE : '0;
					err_q  <= (base != '0) && (exponent != '0) && (modulus == '0);
				end
			end
			ST_RED: begin
				if (cnt_last) begin
					base_q <= red_v;
					acc_q  <= one_mod;
					mp_q   <= '0;
					cnt_q  <= CNT_INIT;
					ma_q   <= exp_q[0] ? one_mod : red_v;
					mb_q   <= red_v;
				end else begin
					cnt_q  <= cnt_q - CW'(1);
					mp_q   <= red_v;
					base_q <= {base_q[WIDTH-2:0], 1'b0};
				end
			end
			ST_MUL: begin
				if (cnt_last) begin
					acc_q <= mp_next;
					mp_q  <= '0;
					cnt_q <= CNT_INIT;
					ma_q  <= base_q;
					mb_q  <= base_q;
				end else begin
					cnt_q <= cnt_q - CW'(1);
					mp_q  <= mp_next;
					ma_q  <= sum_a;
					mb_q  <= mb_q >> 1;
				end
			end
			ST_SQR: begin
				if (cnt_last) begin
					base_q <= mp_next;
					exp_q  <= exp_q >> 1;
					mp_q   <= '0;
					cnt_q  <= CNT_INIT;
					ma_q   <= exp_q[1] ? acc_q : mp_next;
					mb_q   <= mp_next;
				end else begin
					cnt_q <= cnt_q - CW'(1);
					mp_q  <= mp_next;
					ma_q  <= sum_a;
					mb_q  <= mb_q >> 1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					power_q     <= acc_q;
					mod_error_q <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign power     = power_q;
	assign mod_error = mod_error_q;

endmodule

>>> hdl/modexp_checker.sv
`include "modular_exponentiation_top_assert.svh"

module modexp_checker
	import modexp_pkg::*;
#(
	parameter int unsigned WIDTH = ModexpWidth
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic [WIDTH-1:0] base,
	input logic [WIDTH-1:0] exponent,
	input logic [WIDTH-1:0] modulus,
	input logic             out_valid,
	input logic             out_ready,
	input logic [WIDTH-1:0] power,
	input logic             mod_error
);

	// The block works on one word at a time, so it is busy right after an accept.
	`ASSERT_NEXT(busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// An error word always carries a zero power.
	`ASSERT_SAME(error_gives_zero, clk, arst_n, out_valid && mod_error, power == '0)

	// A stalled output word holds.
	`ASSERT_NEXT(out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(power) && $stable(mod_error))

endmodule

bind modular_exponentiation_top modexp_checker #(.WIDTH(WIDTH)) u_modexp_checker (.*);
